// ----- hdl/ibmb_pkg.sv -----
// Package for the block-mean binning block: request types, register indexes,
// controller states and default sizes. Used by the top level and the testbench.
package ibmb_pkg;

    // Default sizes for the top-level parameters.
    localparam int DEF_MAX_OUT_WIDTH = 4096;
    localparam int DEF_MAX_BIN       = 64;

    // Largest frame size in either direction.
    localparam int FRAME_LIMIT = 4096;

    // Configuration register indexes.
    localparam logic [1:0] REG_BIN_WIDTH    = 2'd0;
    localparam logic [1:0] REG_BIN_HEIGHT   = 2'd1;
    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd2;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd3;

    // Input request: one pixel in raster order.
    typedef struct packed {
        logic signed [31:0] pixel_value;
        logic [31:0]        pixel_mask;
    } pixel_in_t;

    // Output request: one binned pixel.
    typedef struct packed {
        logic signed [31:0] mean_value;
        logic [31:0]        mean_mask;
        logic [11:0]        out_column;
        logic [11:0]        out_row;
    } mean_out_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIVIDE,
        ST_ROUND
    } ctrl_state_t;

endpackage

// ----- hdl/image_block_mean_binning.sv -----
// Block-mean image binning top level: counters, line store control, divider.
// Depends on ibmb_pkg and ibmb_ram.
//
// Usage:
// Pixels arrive on in_valid/in_stall/in_data in raster order. Each
// bin_width x bin_height block yields one request on out_valid/out_stall/
// out_data carrying the rounded mean, the OR of masks and the output column
// and row. Columns and rows beyond whole bins are consumed and dropped.
// Configuration is written through cfg_write/cfg_index/cfg_data; the user
// must write it only while idle, which the block itself does not enforce.
// Stalls: a pixel that does not close a kept bin column leaves in_stall low;
// one that closes a bin column holds it through ST_UPDATE (line store read,
// then write back through the single RAM port pair); one that closes a whole
// block also holds it through ST_DIVIDE (bit-serial divider) and ST_ROUND.
// The output register lets a new pixel be taken while a result waits; the
// divider holds its result until the output register is free, so a stalled
// receiver only holds the input side once a second block completes.
// Reset clears counters and restores register defaults (bins 1x1, frame
// 4096x4096), then zeroes every line store entry, one entry per cycle, with
// in_stall held high.
module image_block_mean_binning
    import ibmb_pkg::*;
#(
    parameter int MAX_OUT_WIDTH = DEF_MAX_OUT_WIDTH,
    parameter int MAX_BIN       = DEF_MAX_BIN
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  pixel_in_t   in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output mean_out_t   out_data,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data
);

    localparam int BIN_W = $clog2(MAX_BIN + 1);
    localparam int NW    = 2 * BIN_W;
    localparam int SUM_W = 32 + 2 * BIN_W;
    localparam int CW    = $clog2(SUM_W + 1);
    localparam int AW    = MAX_OUT_WIDTH > 1 ? $clog2(MAX_OUT_WIDTH) : 1;
    localparam int RW    = SUM_W + 32;

    // Configuration registers.
    logic [6:0]  bin_width_reg, bin_height_reg;
    logic [12:0] frame_width_reg, frame_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_width_reg    <= 7'd1;
            bin_height_reg   <= 7'd1;
            frame_width_reg  <= 13'(FRAME_LIMIT);
            frame_height_reg <= 13'(FRAME_LIMIT);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_BIN_WIDTH:    bin_width_reg    <= cfg_data[6:0];
                REG_BIN_HEIGHT:   bin_height_reg   <= cfg_data[6:0];
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Clamped geometry.
    logic [BIN_W-1:0] bw, bh;
    logic [12:0]      fw, fh;

    always_comb
    begin
        if (bin_width_reg == 7'd0)
            bw = BIN_W'(1);
        else if (9'(bin_width_reg) > 9'(MAX_BIN))
            bw = BIN_W'(MAX_BIN);
        else
            bw = BIN_W'(bin_width_reg);

        if (bin_height_reg == 7'd0)
            bh = BIN_W'(1);
        else if (9'(bin_height_reg) > 9'(MAX_BIN))
            bh = BIN_W'(MAX_BIN);
        else
            bh = BIN_W'(bin_height_reg);

        if (frame_width_reg == 13'd0)
            fw = 13'd1;
        else if (frame_width_reg > 13'(FRAME_LIMIT))
            fw = 13'(FRAME_LIMIT);
        else
            fw = frame_width_reg;

        if (frame_height_reg == 13'd0)
            fh = 13'd1;
        else if (frame_height_reg > 13'(FRAME_LIMIT))
            fh = 13'(FRAME_LIMIT);
        else
            fh = frame_height_reg;
    end

    // Control and raster state.
    ctrl_state_t state_reg, state_next;
    logic [11:0]      input_col_reg, input_row_reg;
    logic [BIN_W-1:0] col_in_bin_reg, row_in_bin_reg;
    logic [11:0]      output_col_reg, output_row_reg;
    logic signed [SUM_W-1:0] run_sum_reg;
    logic [31:0]      run_mask_reg;

    // Pending block column held between accept and write back.
    logic signed [SUM_W-1:0] pend_sum_reg;
    logic [31:0]      pend_mask_reg;
    logic [AW-1:0]    pend_addr_reg;
    logic             pend_add_reg, pend_emit_reg;
    logic [11:0]      pend_col_reg, pend_row_reg;
    logic [NW-1:0]    div_n_reg;

    // Divider state.
    logic [SUM_W-1:0] quo_reg;
    logic [NW:0]      rem_reg;
    logic [CW-1:0]    div_cnt_reg;
    logic             div_neg_reg;
    logic [31:0]      div_mask_reg;

    // Output register.
    logic      out_valid_reg;
    mean_out_t out_data_reg;

    // Line store.
    logic          ram_we, ram_re;
    logic [RW-1:0] ram_wdata, ram_rdata;
    logic [AW-1:0] ram_raddr;

    // Line store clearing pass after reset, one entry per cycle.
    logic          clear_busy_reg;
    logic [AW-1:0] clear_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_busy_reg <= 1'b1;
            clear_addr_reg <= '0;
        end
        else if (clear_busy_reg)
        begin
            clear_addr_reg <= clear_addr_reg + AW'(1);
            if (clear_addr_reg == AW'(MAX_OUT_WIDTH - 1))
                clear_busy_reg <= 1'b0;
        end
    end

    // The clearing pass owns the write port until it ends.
    logic          store_we;
    logic [AW-1:0] store_waddr;
    logic [RW-1:0] store_wdata;

    assign store_we    = ram_we || clear_busy_reg;
    assign store_waddr = clear_busy_reg ? clear_addr_reg : pend_addr_reg;
    assign store_wdata = clear_busy_reg ? '0 : ram_wdata;

    ibmb_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_OUT_WIDTH)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (store_we),
        .wr_addr (store_waddr),
        .wr_data (store_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // Accept-time decode.
    logic accept;
    logic col_end, row_end, band_last, frame_col_end, frame_row_end;
    logic col_fits, row_fits, active;
    logic [12+BIN_W:0] col_extent, row_extent;
    logic signed [SUM_W-1:0] new_run;
    logic [31:0] new_mask;

    assign in_stall = (state_reg != ST_IDLE) || clear_busy_reg;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        col_end       = (BIN_W'(col_in_bin_reg) + (BIN_W+1)'(1)) >= (BIN_W+1)'(bw);
        band_last     = ((BIN_W+1)'(row_in_bin_reg) + (BIN_W+1)'(1)) >= (BIN_W+1)'(bh);
        row_end       = band_last;
        frame_col_end = (13'(input_col_reg) + 13'd1) >= fw;
        frame_row_end = (13'(input_row_reg) + 13'd1) >= fh;
        col_extent    = (13+BIN_W)'(13'(output_col_reg) + 13'd1) * (13+BIN_W)'(bw);
        row_extent    = (13+BIN_W)'(13'(output_row_reg) + 13'd1) * (13+BIN_W)'(bh);
        col_fits      = col_extent <= (13+BIN_W)'(fw)
                        && 32'(output_col_reg) < 32'(MAX_OUT_WIDTH);
        row_fits      = row_extent <= (13+BIN_W)'(fh);
        active        = col_fits && row_fits;
        new_run       = run_sum_reg + SUM_W'(in_data.pixel_value);
        new_mask      = run_mask_reg | in_data.pixel_mask;
        ram_re        = accept && active && col_end && (row_in_bin_reg != '0);
        ram_raddr     = AW'(output_col_reg);
    end

    // Write back of the merged column entry.
    logic signed [SUM_W-1:0] merged_sum;
    logic [31:0]             merged_mask;

    always_comb
    begin
        merged_sum  = pend_sum_reg;
        merged_mask = pend_mask_reg;
        if (pend_add_reg)
        begin
            merged_sum  = pend_sum_reg + $signed(ram_rdata[RW-1:32]);
            merged_mask = pend_mask_reg | ram_rdata[31:0];
        end
        ram_we    = (state_reg == ST_UPDATE);
        ram_wdata = {merged_sum, merged_mask};
    end

    // One restoring divide step per cycle.
    logic [NW:0] rem_shift;
    logic        rem_ge;

    always_comb
    begin
        rem_shift = {rem_reg[NW-1:0], quo_reg[SUM_W-1]};
        rem_ge    = rem_shift >= {1'b0, div_n_reg};
    end

    // Rounding half to even and sign restore.
    logic [NW+1:0]    rem_twice;
    logic             round_up;
    logic [SUM_W-1:0] quo_rounded, mean_full;

    always_comb
    begin
        rem_twice   = {rem_reg, 1'b0};
        round_up    = rem_twice > {2'b00, div_n_reg}
                      || (rem_twice == {2'b00, div_n_reg} && quo_reg[0]);
        quo_rounded = quo_reg + SUM_W'(round_up);
        mean_full   = div_neg_reg ? (SUM_W'(0) - quo_rounded) : quo_rounded;
    end

    logic out_free;
    assign out_free = !out_valid_reg || !out_stall;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (accept && active && col_end)
                    state_next = ST_UPDATE;
            ST_UPDATE:
                state_next = pend_emit_reg ? ST_DIVIDE : ST_IDLE;
            ST_DIVIDE:
                if (div_cnt_reg == CW'(SUM_W - 1))
                    state_next = ST_ROUND;
            ST_ROUND:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Raster counters and running horizontal sum.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            input_col_reg  <= '0;
            input_row_reg  <= '0;
            col_in_bin_reg <= '0;
            row_in_bin_reg <= '0;
            output_col_reg <= '0;
            output_row_reg <= '0;
            run_sum_reg    <= '0;
            run_mask_reg   <= '0;
        end
        else if (accept)
        begin
            if (active && !col_end)
            begin
                run_sum_reg  <= new_run;
                run_mask_reg <= new_mask;
            end
            else if (active)
            begin
                run_sum_reg  <= '0;
                run_mask_reg <= '0;
            end

            if (col_end)
            begin
                col_in_bin_reg <= '0;
                output_col_reg <= output_col_reg + 12'd1;
            end
            else
            begin
                col_in_bin_reg <= col_in_bin_reg + BIN_W'(1);
            end

            if (frame_col_end)
            begin
                input_col_reg  <= '0;
                col_in_bin_reg <= '0;
                output_col_reg <= '0;
                run_sum_reg    <= '0;
                run_mask_reg   <= '0;
                if (frame_row_end)
                begin
                    input_row_reg  <= '0;
                    row_in_bin_reg <= '0;
                    output_row_reg <= '0;
                end
                else
                begin
                    input_row_reg <= input_row_reg + 12'd1;
                    if (row_end)
                    begin
                        row_in_bin_reg <= '0;
                        output_row_reg <= output_row_reg + 12'd1;
                    end
                    else
                    begin
                        row_in_bin_reg <= row_in_bin_reg + BIN_W'(1);
                    end
                end
            end
            else
            begin
                input_col_reg <= input_col_reg + 12'd1;
            end
        end
    end

    // Pending column capture (payload, no reset).
    always_ff @(posedge clk)
    begin
        if (accept && active && col_end)
        begin
            pend_sum_reg  <= new_run;
            pend_mask_reg <= new_mask;
            pend_addr_reg <= AW'(output_col_reg);
            pend_add_reg  <= (row_in_bin_reg != '0);
            pend_emit_reg <= band_last;
            pend_col_reg  <= output_col_reg;
            pend_row_reg  <= output_row_reg;
            div_n_reg     <= NW'(bw) * NW'(bh);
        end
    end

    // Divider datapath.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
        end
        else if (state_reg == ST_UPDATE)
        begin
            div_cnt_reg <= '0;
        end
        else if (state_reg == ST_DIVIDE)
        begin
            div_cnt_reg <= div_cnt_reg + CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_UPDATE)
        begin
            div_neg_reg  <= merged_sum[SUM_W-1];
            quo_reg      <= merged_sum[SUM_W-1] ? (SUM_W'(0) - merged_sum) : merged_sum;
            rem_reg      <= '0;
            div_mask_reg <= merged_mask;
        end
        else if (state_reg == ST_DIVIDE)
        begin
            quo_reg <= {quo_reg[SUM_W-2:0], rem_ge};
            rem_reg <= rem_ge ? (rem_shift - {1'b0, div_n_reg}) : rem_shift;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == ST_ROUND && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_ROUND && out_free)
        begin
            out_data_reg.mean_value <= $signed(mean_full[31:0]);
            out_data_reg.mean_mask  <= div_mask_reg;
            out_data_reg.out_column <= pend_col_reg;
            out_data_reg.out_row    <= pend_row_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Checks.
    a_update_to_divide: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_UPDATE && pend_emit_reg |=> state_reg == ST_DIVIDE)
        else $error("block end did not start the divider");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIVIDE |-> div_cnt_reg < CW'(SUM_W))
        else $error("divider ran past its step count");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ROUND && out_valid_reg && out_stall |=> state_reg == ST_ROUND)
        else $error("result left the divider while the output was stalled");

    a_no_read_on_write: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !ram_re)
        else $error("line store read overlapped its write back");

endmodule

// ----- hdl/ibmb_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// Stand-alone; no package dependency.
module ibmb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- tb/sv/tb_image_block_mean_binning.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for image_block_mean_binning: random pixel streams
// over many bin and frame settings, checked against an in-bench predictor.
// Depends on ibmb_pkg and the block's RTL.

import ibmb_pkg::*;

// Scoreboard: predicts the binned means and checks every delivered request.
class binning_scoreboard;
    logic [6:0]  bin_w_reg;
    logic [6:0]  bin_h_reg;
    logic [12:0] frame_w_reg;
    logic [12:0] frame_h_reg;
    longint      col_sum [FRAME_LIMIT];
    logic [31:0] col_mask [FRAME_LIMIT];
    longint      run_sum;
    logic [31:0] run_mask;
    int unsigned in_col, in_row, col_in_bin, row_in_bin, out_col, out_row;
    mean_out_t   expected_means[$];
    int          mismatches;
    int          failures;

    function new();
        bin_w_reg   = 7'd1;
        bin_h_reg   = 7'd1;
        frame_w_reg = 13'd4096;
        frame_h_reg = 13'd4096;
        foreach (col_sum[i])
        begin
            col_sum[i]  = 0;
            col_mask[i] = '0;
        end
        run_sum    = 0;
        run_mask   = '0;
        in_col     = 0;
        in_row     = 0;
        col_in_bin = 0;
        row_in_bin = 0;
        out_col    = 0;
        out_row    = 0;
        mismatches = 0;
        failures   = 0;
    endfunction

    function int unsigned clamp(int unsigned v, int unsigned hi);
        if (v == 0)
            return 1;
        return (v > hi) ? hi : v;
    endfunction

    // Symmetric round half to even of sum / count.
    function longint rounded_mean(longint s, longint n);
        longint a;
        longint q;
        longint r;
        a = (s < 0) ? -s : s;
        q = a / n;
        r = a % n;
        if (2 * r > n || (2 * r == n && q[0]))
            q++;
        return (s < 0) ? -q : q;
    endfunction

    function void write_reg(logic [1:0] idx, logic [12:0] data);
        case (idx)
            REG_BIN_WIDTH:    bin_w_reg   = data[6:0];
            REG_BIN_HEIGHT:   bin_h_reg   = data[6:0];
            REG_FRAME_WIDTH:  frame_w_reg = data;
            REG_FRAME_HEIGHT: frame_h_reg = data;
            default: ;
        endcase
    endfunction

    // Called for every accepted pixel request.
    function void note_pixel(pixel_in_t px);
        int unsigned bw, bh, fw, fh;
        longint      s;
        logic [31:0] m;
        mean_out_t   res;
        bw = clamp(bin_w_reg, DEF_MAX_BIN);
        bh = clamp(bin_h_reg, DEF_MAX_BIN);
        fw = clamp(frame_w_reg, FRAME_LIMIT);
        fh = clamp(frame_h_reg, FRAME_LIMIT);
        if (out_col < fw / bw && out_col < DEF_MAX_OUT_WIDTH && out_row < fh / bh)
        begin
            run_sum  += longint'(px.pixel_value);
            run_mask |= px.pixel_mask;
            if (col_in_bin + 1 >= bw)
            begin
                s = run_sum;
                m = run_mask;
                // The first row of a band overwrites the stored column.
                if (row_in_bin != 0)
                begin
                    s += col_sum[out_col];
                    m |= col_mask[out_col];
                end
                col_sum[out_col]  = s;
                col_mask[out_col] = m;
                if (row_in_bin + 1 >= bh)
                begin
                    res.mean_value = 32'(rounded_mean(s, longint'(bw) * longint'(bh)));
                    res.mean_mask  = m;
                    res.out_column = out_col[11:0];
                    res.out_row    = out_row[11:0];
                    expected_means.push_back(res);
                end
                run_sum  = 0;
                run_mask = '0;
            end
        end
        // Raster counters.
        if (col_in_bin + 1 >= bw)
        begin
            col_in_bin = 0;
            out_col    = (out_col + 1) & 12'hFFF;
        end
        else
            col_in_bin++;
        if (in_col + 1 >= fw)
        begin
            in_col     = 0;
            col_in_bin = 0;
            out_col    = 0;
            run_sum    = 0;
            run_mask   = '0;
            if (row_in_bin + 1 >= bh)
            begin
                row_in_bin = 0;
                out_row    = (out_row + 1) & 12'hFFF;
            end
            else
                row_in_bin++;
            if (in_row + 1 >= fh)
            begin
                in_row     = 0;
                row_in_bin = 0;
                out_row    = 0;
            end
            else
                in_row++;
        end
        else
            in_col++;
    endfunction

    // Called for every accepted output request.
    function void check_mean(mean_out_t got);
        mean_out_t want;
        if (expected_means.size() == 0)
        begin
            failures++;
            if (mismatches++ < 10)
                $display("unexpected output request: mean %0d mask %h col %0d row %0d",
                         got.mean_value, got.mean_mask, got.out_column, got.out_row);
            return;
        end
        want = expected_means.pop_front();
        if (got.mean_value !== want.mean_value || got.mean_mask !== want.mean_mask ||
            got.out_column !== want.out_column || got.out_row !== want.out_row)
        begin
            failures++;
            if (mismatches++ < 10)
                $display("mismatch: expected mean %0d mask %h col %0d row %0d,",
                         want.mean_value, want.mean_mask, want.out_column, want.out_row,
                         " got mean %0d mask %h col %0d row %0d",
                         got.mean_value, got.mean_mask, got.out_column, got.out_row);
        end
    endfunction

    function int pending();
        return expected_means.size();
    endfunction
endclass

module tb_image_block_mean_binning;

    localparam int IDLE_LIMIT  = 20000;
    localparam int SETTLE_GAP  = 80;
    localparam int TARGET_ITEMS = 1300;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    pixel_in_t   in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    mean_out_t   out_data;
    logic        cfg_write = 1'b0;
    logic [1:0]  cfg_index = REG_BIN_WIDTH;
    logic [12:0] cfg_data = '0;

    binning_scoreboard sb = new();
    int burst_left = 0;
    int sent_items = 0;
    int idle_cycles = 0;
    int stall_mode = 0;
    int stall_count = 0;

    image_block_mean_binning u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Receiver stall pattern: free running, random, or long stall bursts.
    always @(posedge clk)
    begin
        if (stall_count == 0)
        begin
            stall_mode  <= $urandom_range(0, 2);
            stall_count <= $urandom_range(16, 96);
            out_stall   <= 1'b0;
        end
        else
        begin
            stall_count <= stall_count - 1;
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= 1'($urandom_range(0, 1));
                default: out_stall <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // Output monitor.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_mean(out_data);
    end

    // Watchdog on cycles with no accepted request or register write.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Drives one pixel request and waits for it to be accepted.
    task automatic send_pixel(logic signed [31:0] value, logic [31:0] mask);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= '{pixel_value: value, pixel_mask: mask};
        do
            @(posedge clk);
        while (in_stall);
        sb.note_pixel('{pixel_value: value, pixel_mask: mask});
        sent_items++;
    endtask

    task automatic send_random_pixel();
        logic signed [31:0] v;
        logic [31:0]        m;
        case ($urandom_range(0, 5))
            0: v = 32'sh7FFFFFFF;
            1: v = 32'sh80000000;
            2, 3: v = $signed($urandom_range(0, 8)) - 4;
            default: v = $urandom;
        endcase
        m = ($urandom_range(0, 1) == 0) ? (32'h1 << $urandom_range(0, 31)) : $urandom;
        send_pixel(v, m);
    endtask

    // Waits until every expected result has arrived and the block has settled.
    task automatic drain();
        in_valid <= 1'b0;
        burst_left = 0;
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (SETTLE_GAP) @(posedge clk);
    endtask

    // Writes all four registers while the block is idle.
    task automatic configure(logic [12:0] bw, logic [12:0] bh, logic [12:0] fw,
                             logic [12:0] fh);
        logic [12:0] vals [4];
        vals = '{bw, bh, fw, fh};
        drain();
        for (int i = 0; i < 4; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= i[1:0];
            cfg_data  <= vals[i];
            @(posedge clk);
            sb.write_reg(i[1:0], vals[i]);
        end
        cfg_write <= 1'b0;
    endtask

    function automatic logic [12:0] pick_bin();
        case ($urandom_range(0, 9))
            0: return 13'd0;
            1: return 13'd127;
            2: return 13'($urandom_range(0, 8191));
            default: return 13'($urandom_range(1, 4));
        endcase
    endfunction

    function automatic logic [12:0] pick_frame(int unsigned hi);
        case ($urandom_range(0, 9))
            0: return 13'd0;
            1: return 13'($urandom_range(0, 8191));
            default: return 13'($urandom_range(1, hi));
        endcase
    endfunction

    initial
    begin
        int phase;
        int count;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset geometry is 1x1 bins: each pixel comes straight back.
        send_pixel(32'sh7FFFFFFF, 32'hFFFFFFFF);
        send_pixel(32'sh80000000, 32'h00000000);
        send_pixel(0, 32'h80000001);
        send_pixel(-1, 32'h55555555);
        send_pixel(1, 32'hAAAAAAAA);

        // Pairs whose means land on halves, plus the sum extremes.
        configure(13'd2, 13'd1, 13'd8, 13'd2);
        send_pixel(1, 32'h1);
        send_pixel(0, 32'h2);
        send_pixel(1, 32'h0);
        send_pixel(2, 32'h0);
        send_pixel(-1, 32'h0);
        send_pixel(0, 32'h4);
        send_pixel(-3, 32'h0);
        send_pixel(0, 32'h0);
        send_pixel(32'sh7FFFFFFF, 32'h0);
        send_pixel(32'sh7FFFFFFF, 32'h0);
        send_pixel(32'sh80000000, 32'h0);
        send_pixel(32'sh80000000, 32'hFFFFFFFF);
        send_pixel(32'sh7FFFFFFF, 32'h0);
        send_pixel(32'sh80000000, 32'h0);
        send_pixel(5, 32'h0);
        send_pixel(-2, 32'h0);

        // Fixed extreme settings first, then random geometries.
        phase = 0;
        while (sent_items < TARGET_ITEMS)
        begin
            case (phase)
                0: configure(13'd0, 13'd0, 13'd0, 13'd0);
                1: configure(13'd127, 13'd2, 13'd70, 13'd2);
                2: configure(13'd1, 13'd127, 13'd3, 13'd70);
                3: configure(13'd3, 13'd1, 13'd8191, 13'd5);
                4: configure(13'd64, 13'd1, 13'd4096, 13'd4096);
                default: configure(pick_bin(), pick_bin(), pick_frame(16), pick_frame(6));
            endcase
            case (phase)
                1: count = 280;
                2: count = 200;
                default: count = $urandom_range(30, 110);
            endcase
            repeat (count) send_random_pixel();
            phase++;
        end

        drain();
        if (sb.failures == 0 && sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- image_block_mean_binning.f -----
hdl/ibmb_pkg.sv
hdl/ibmb_ram.sv
hdl/image_block_mean_binning.sv
tb/sv/tb_image_block_mean_binning.sv
